// ===== src/mswp_pkg.sv =====
// Package: constants, state type and widths for the middle-square Weyl generator.
package mswp_pkg;

  localparam int unsigned HalfW   = 36;
  localparam int unsigned StateW  = 2 * HalfW;
  localparam int unsigned DrawW   = 24;
  localparam int unsigned RangeW  = DrawW + 1;
  localparam int unsigned DivSteps = RangeW;
  localparam int unsigned DivCntW = $clog2(DivSteps);
  localparam int unsigned MulSteps = 4;
  localparam int unsigned MulCntW = $clog2(MulSteps + 1);
  localparam int unsigned PartW   = HalfW / 2;
  localparam int unsigned ProdW   = HalfW + PartW;

  localparam logic [StateW-1:0] WEYL_K       = 72'hD9B5AD4ECEDA1CE2A9;
  localparam logic [HalfW-1:0]  SEED_LOW_RST = 36'h000001234;
  localparam logic [HalfW-1:0]  SEED_HIGH_RST = '0;
  localparam logic [RangeW-1:0] FULL_RANGE   = 25'h1000000;

  localparam logic REG_SEED_LOW  = 1'b0;
  localparam logic REG_SEED_HIGH = 1'b1;

  localparam logic KIND_RAW  = 1'b0;
  localparam logic KIND_DICE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVD,
    ST_MUL,
    ST_WEYL,
    ST_MIX,
    ST_DIVR,
    ST_OUT
  } state_e;

endpackage

// ===== src/middle_square_weyl_prng_dice_core.sv =====
// Top level: 72-bit middle-square Weyl generator with raw and dice draws.
//
// Input stream: s_axis_tuser selects the kind (0 raw draw, 1 dice), s_axis_tdata
// carries range_n. Output stream: m_axis_tdata carries the 24-bit value.
// APB port: seed_low at 0x0, seed_high at 0x8; a write reloads the square
// state from the seed and clears the Weyl sum.
//
// One transfer is taken at a time; s_axis_tready is low while it is worked on.
// A draw squares the state on one shared 36x18 multiplier in four partial
// products, then adds the Weyl constant and mixes. Raw: the result is loaded
// into the output register after the mix; the next input can be taken once
// the block is back in idle. Dice: d = 2^24/range is found first on the
// shared one-bit-a-cycle divider, then each draw is followed by its quotient
// on that divider, repeated until the quotient is below range; then the
// output register is loaded.
// The result waits in the output register; a stalled receiver holds the
// block after its next item finishes, until that register is free.
// Reset loads seed 0x1234, clears the Weyl sum and empties the output.
module middle_square_weyl_prng_dice_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [24:0] range_n
  input  logic [0:0]  s_axis_tuser,   // [0] kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [23:0] value
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import mswp_pkg::*;

  state_e state_q, state_d;

  logic [HalfW-1:0]  seed_low_q, seed_high_q;
  logic [StateW-1:0] x_q, w_q, acc_q;
  logic [ProdW-1:0]  prod_q;
  logic [MulCntW-1:0] mul_cnt_q;
  logic              kind_q;
  logic [RangeW-1:0] n_q, d_q;
  logic [RangeW-1:0] div_rem_q;
  logic [RangeW-1:0] div_quo_q, div_dsr_q;
  logic [DivCntW-1:0] div_cnt_q;
  logic              m_valid_q;
  logic [DrawW-1:0]  m_data_q;

  logic              s_acc, cfg_wr, div_last, quo_ok;
  logic              div_init_d, div_init_r, div_run, mul_run, weyl_en, mix_en, out_load;
  logic [RangeW-1:0] n_clamp, range_in;
  logic [RangeW:0]   rem_sh, rem_sub;
  logic              rem_ge;
  logic [RangeW-1:0] quo_next;
  logic [HalfW-1:0]  mul_a;
  logic [PartW-1:0]  mul_b;
  logic [StateW-1:0] term, mix_sum;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;
  assign prdata = (paddr[3] == REG_SEED_HIGH) ? {28'd0, seed_high_q} : {28'd0, seed_low_q};

  assign s_acc    = s_axis_tvalid & s_axis_tready;
  assign range_in = s_axis_tdata[RangeW-1:0];
  assign n_clamp  = (range_in == '0) ? RangeW'(1) :
                    (range_in > FULL_RANGE) ? FULL_RANGE : range_in;

  // restoring divider step
  assign rem_sh   = {div_rem_q[RangeW-1:0], div_quo_q[RangeW-1]};
  assign rem_ge   = rem_sh >= {1'b0, div_dsr_q};
  assign rem_sub  = rem_sh - {1'b0, div_dsr_q};
  assign quo_next = {div_quo_q[RangeW-2:0], rem_ge};
  assign div_last = div_cnt_q == DivCntW'(DivSteps - 1);
  assign quo_ok   = quo_next < n_q;

  // partial product operands: l*b, l*a, h*b, h*a
  always_comb begin
    case (mul_cnt_q[1:0])
      2'd0:    begin mul_a = x_q[HalfW-1:0];      mul_b = x_q[PartW-1:0];     end
      2'd1:    begin mul_a = x_q[HalfW-1:0];      mul_b = x_q[HalfW-1:PartW]; end
      2'd2:    begin mul_a = x_q[StateW-1:HalfW]; mul_b = x_q[PartW-1:0];     end
      default: begin mul_a = x_q[StateW-1:HalfW]; mul_b = x_q[HalfW-1:PartW]; end
    endcase
  end

  always_comb begin
    case (mul_cnt_q)
      MulCntW'(2): term = {{(StateW-ProdW){1'b0}}, prod_q} << PartW;
      MulCntW'(3): term = {{(StateW-ProdW){1'b0}}, prod_q} << (HalfW + 1);
      MulCntW'(4): term = {{(StateW-ProdW){1'b0}}, prod_q} << (HalfW + PartW + 1);
      default:     term = {{(StateW-ProdW){1'b0}}, prod_q};
    endcase
  end

  assign mix_sum = acc_q + w_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (s_acc) state_d = (s_axis_tuser[0] == KIND_DICE) ? ST_DIVD : ST_MUL;
      ST_DIVD: if (div_last) state_d = ST_MUL;
      ST_MUL:  if (mul_cnt_q == MulCntW'(MulSteps)) state_d = ST_WEYL;
      ST_WEYL: state_d = ST_MIX;
      ST_MIX:  state_d = (kind_q == KIND_DICE) ? ST_DIVR : ST_OUT;
      ST_DIVR: if (div_last) state_d = quo_ok ? ST_OUT : ST_MUL;
      ST_OUT:  if (!m_valid_q || m_axis_tready) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = state_q == ST_IDLE;
    div_init_d    = (state_q == ST_IDLE) && s_acc && (s_axis_tuser[0] == KIND_DICE);
    div_init_r    = (state_q == ST_MIX) && (kind_q == KIND_DICE);
    div_run       = (state_q == ST_DIVD) || (state_q == ST_DIVR);
    mul_run       = state_q == ST_MUL;
    weyl_en       = state_q == ST_WEYL;
    mix_en        = state_q == ST_MIX;
    out_load      = (state_q == ST_OUT) && (!m_valid_q || m_axis_tready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      seed_low_q  <= SEED_LOW_RST;
      seed_high_q <= SEED_HIGH_RST;
      x_q         <= {SEED_HIGH_RST, SEED_LOW_RST};
      w_q         <= '0;
      mul_cnt_q   <= '0;
      div_cnt_q   <= '0;
      m_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_wr) begin
        if (paddr[3] == REG_SEED_HIGH) begin
          seed_high_q <= pwdata[HalfW-1:0];
          x_q         <= {pwdata[HalfW-1:0], seed_low_q};
        end else begin
          seed_low_q <= pwdata[HalfW-1:0];
          x_q        <= {seed_high_q, pwdata[HalfW-1:0]};
        end
      end else if (mix_en) begin
        x_q <= {mix_sum[HalfW-1:0], mix_sum[StateW-1:HalfW]};
      end
      if (cfg_wr) w_q <= '0;
      else if (weyl_en) w_q <= w_q + WEYL_K;
      if (mul_run) mul_cnt_q <= (mul_cnt_q == MulCntW'(MulSteps)) ? '0 : mul_cnt_q + 1'b1;
      if (div_init_d || div_init_r) div_cnt_q <= '0;
      else if (div_run) div_cnt_q <= div_last ? '0 : div_cnt_q + 1'b1;
      if (out_load) m_valid_q <= 1'b1;
      else if (m_axis_tready) m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      kind_q <= s_axis_tuser[0];
      n_q    <= n_clamp;
    end
    if (mul_run) begin
      prod_q <= mul_a * mul_b;
      if (mul_cnt_q == '0) acc_q <= '0;
      else acc_q <= acc_q + term;
    end
    if (div_init_d) begin
      div_rem_q <= '0;
      div_quo_q <= FULL_RANGE;
      div_dsr_q <= n_clamp;
    end else if (div_init_r) begin
      div_rem_q <= '0;
      div_quo_q <= {1'b0, mix_sum[HalfW+DrawW-1:HalfW]};
      div_dsr_q <= d_q;
    end else if (div_run) begin
      div_rem_q <= rem_ge ? rem_sub[RangeW-1:0] : rem_sh[RangeW-1:0];
      div_quo_q <= quo_next;
    end
    if ((state_q == ST_DIVD) && div_last) d_q <= quo_next;
    // raw draw sits in the low bits of the mixed state, dice result in the quotient
    if (out_load) m_data_q <= (kind_q == KIND_RAW) ? x_q[DrawW-1:0] : div_quo_q[DrawW-1:0];
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

// ===== src/mswp_checker.sv =====
// Checker: port-level properties of the generator core, bound to the top level.
module mswp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        pready
);

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken while busy");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!m_axis_tvalid ##1 m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared without work");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind middle_square_weyl_prng_dice_core mswp_checker u_mswp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .pready        (pready)
);

// ===== sim/middle_square_weyl_prng_dice_core_tb.sv =====
`timescale 1ns / 1ps
// Testbench for the middle-square Weyl generator: raw and dice draws checked against a predictor.
module middle_square_weyl_prng_dice_core_tb;
  import mswp_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 2_000_000;
  localparam int unsigned PHASE_ITEMS  = 230;
  localparam int unsigned NUM_PHASES   = 5;
  localparam int unsigned TAIL_CYCLES  = 64;
  localparam logic [HalfW-1:0] ONES36  = '1;

  class dice_scoreboard;
    logic [HalfW-1:0]  seed_lo;
    logic [HalfW-1:0]  seed_hi;
    logic [StateW-1:0] square_x;
    logic [StateW-1:0] weyl_w;
    logic [DrawW-1:0]  expected_values[$];
    int unsigned       errors;

    function new();
      seed_lo = SEED_LOW_RST;
      seed_hi = SEED_HIGH_RST;
      errors  = 0;
      reload();
    endfunction

    function void reload();
      square_x = {seed_hi, seed_lo};
      weyl_w   = '0;
    endfunction

    function void write_seed(logic idx, logic [HalfW-1:0] value);
      if (idx == REG_SEED_LOW) begin
        seed_lo = value;
      end else begin
        seed_hi = value;
      end
      reload();
    endfunction

    function logic [DrawW-1:0] next_draw();
      square_x = square_x * square_x;
      weyl_w   = weyl_w + WEYL_K;
      square_x = square_x + weyl_w;
      square_x = {square_x[HalfW-1:0], square_x[StateW-1:HalfW]};
      return square_x[DrawW-1:0];
    endfunction

    function void note_request(logic kind, logic [RangeW-1:0] range_n);
      logic [RangeW-1:0] n;
      logic [RangeW-1:0] d;
      logic [RangeW-1:0] q;
      if (kind == KIND_RAW) begin
        expected_values.push_back(next_draw());
      end else begin
        n = range_n;
        if (n == 0) n = 1;
        if (n > FULL_RANGE) n = FULL_RANGE;
        d = FULL_RANGE / n;
        do begin
          q = {1'b0, next_draw()} / d;
        end while (q >= n);
        expected_values.push_back(q[DrawW-1:0]);
      end
    endfunction

    function void check_value(logic [DrawW-1:0] got);
      logic [DrawW-1:0] want;
      if (expected_values.size() == 0) begin
        errors++;
        if (errors <= 10) $display("%0t: unexpected value %h", $time, got);
      end else begin
        want = expected_values.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) $display("%0t: value mismatch: expected %h, got %h", $time, want, got);
        end
      end
    endfunction

    function int unsigned pending();
      return expected_values.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // [24:0] range_n
  logic [0:0]  s_axis_tuser = '0;   // [0] kind
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;        // [23:0] value
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  dice_scoreboard sb;
  bit             tx_steady = 1'b0;
  bit             rx_steady = 1'b0;
  int unsigned    rx_hold = 0;
  int unsigned    cycles = 0;

  middle_square_weyl_prng_dice_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned pick_gap(bit steady);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [HalfW-1:0] rand36();
    return HalfW'({$urandom(), $urandom()});
  endfunction

  always @(posedge clk_i) begin
    if (rx_hold != 0) begin
      rx_hold       <= rx_hold - 1;
      m_axis_tready <= 1'b0;
    end else if (!rx_steady && $urandom_range(0, 3) == 0) begin
      rx_hold       <= pick_gap(1'b0);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_value(m_axis_tdata);
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_item(logic kind, logic [RangeW-1:0] range_n);
    int unsigned gap;
    gap = pick_gap(tx_steady);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, range_n};
    s_axis_tuser  <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(kind, range_n);
  endtask

  // sender holds off until every outstanding result has been taken
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  // psel is left high so that writes may follow back to back
  task automatic write_seed(logic idx, logic [HalfW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= {28'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    sb.write_seed(idx, value);
  endtask

  task automatic apb_release();
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic run_directed();
    logic [RangeW-1:0] dice_ranges[15];
    dice_ranges = '{25'd0, 25'd1, 25'd2, 25'd3, 25'd6, 25'd7, 25'd100,
                    25'h0800000, 25'h0800001, 25'h0FFFFFF, 25'h1000000,
                    25'h1000001, 25'h1555555, 25'h1FFFFFF, 25'h0AAAAAA};
    send_item(KIND_RAW, '0);
    send_item(KIND_RAW, '1);
    send_item(KIND_RAW, 25'h0AAAAAA);
    foreach (dice_ranges[i]) send_item(KIND_DICE, dice_ranges[i]);
  endtask

  task automatic send_random();
    logic              kind;
    logic [RangeW-1:0] range_n;
    kind = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 9))
      0:       range_n = '0;
      1, 2, 3: range_n = RangeW'($urandom_range(1, 16));
      4, 5:    range_n = RangeW'($urandom_range(1, 1000));
      6:       range_n = RangeW'($urandom_range(25'h0800000, 25'h0800100));
      7:       range_n = RangeW'($urandom_range(1, 25'h1000000));
      8:       range_n = RangeW'($urandom_range(25'h1000000, 25'h1FFFFFF));
      default: range_n = RangeW'($urandom());
    endcase
    send_item(kind, range_n);
  endtask

  initial begin
    sb = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    run_directed();
    drain();
    for (int p = 0; p < NUM_PHASES; p++) begin
      tx_steady = (p == 3);
      rx_steady = (p == 2);
      case (p)
        0: begin
          write_seed(REG_SEED_LOW, '0);
          write_seed(REG_SEED_HIGH, '0);
        end
        1: begin
          write_seed(REG_SEED_HIGH, ONES36);
          write_seed(REG_SEED_LOW, ONES36);
        end
        2: write_seed(REG_SEED_HIGH, rand36());
        default: begin
          write_seed(REG_SEED_LOW, rand36());
          write_seed(REG_SEED_HIGH, rand36());
        end
      endcase
      apb_release();
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i == PHASE_ITEMS / 2) drain();
        send_random();
      end
      drain();
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/mswp_pkg.sv
src/middle_square_weyl_prng_dice_core.sv
src/mswp_checker.sv
sim/middle_square_weyl_prng_dice_core_tb.sv
